>>> rtl/core/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg: shared types and constants of the axis selectable distance block
// Widths of the coordinate datapath, axis mode codes, the request and result
// payload types and the record that moves down the square root cell chain.
// ----------------------------------------------------------------------------
package asd_pkg;

   // Coordinate width; all datapath widths follow from it.
   localparam int COORD_BITS = 32;
   // A difference of two coordinates needs one more bit.
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // The square of a difference is at most 2^(2*COORD_BITS).
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   // A sum of three squares stays below 2^(2*COORD_BITS+2).
   localparam int RAD_BITS   = 2 * COORD_BITS + 2;
   // One root bit per cell.
   localparam int ROOT_BITS  = RAD_BITS / 2;
   // Partial remainder with room for the two shifted-in bits.
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int DIST_BITS  = COORD_BITS + 2;
   // Three front stages, one stage per cell and the result register.
   localparam int LATENCY    = ROOT_BITS + 4;

   // Axis mode codes.
   localparam logic [2:0] FUNC_ALL = 3'd0;
   localparam logic [2:0] FUNC_X   = 3'd1;
   localparam logic [2:0] FUNC_Y   = 3'd2;
   localparam logic [2:0] FUNC_Z   = 3'd3;
   localparam logic [2:0] FUNC_XY  = 3'd4;
   localparam logic [2:0] FUNC_XZ  = 3'd5;
   localparam logic [2:0] FUNC_YZ  = 3'd6;
   localparam logic [2:0] FUNC_BAD = 3'd7;

   typedef struct packed {
      logic [2:0]                   func;
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] a_z;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] dist_res;
      logic                 mode_error;
   } rsp_type;

   // Record handed from one square root cell to the next.
   typedef struct packed {
      logic                 valid;
      logic                 sqrt_en;
      logic                 err;
      logic [DIFF_BITS-1:0] direct;
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } cell_type;

endpackage

>>> rtl/core/asd_front.sv
// ----------------------------------------------------------------------------
// asd_front: difference, square and sum stages
// Three pipeline stages that form the coordinate differences, their squares
// and absolute values, and the sum of squares chosen by the axis mode.
// ----------------------------------------------------------------------------
module asd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  asd_pkg::req_type in_req,
   output asd_pkg::cell_type out_cell
);

   localparam int C = asd_pkg::COORD_BITS;

   logic                                  s1_valid_ff;
   logic [2:0]                            s1_func_ff;
   logic signed [asd_pkg::DIFF_BITS-1:0]  s1_dx_ff, s1_dy_ff, s1_dz_ff;

   logic                                  s2_valid_ff;
   logic [2:0]                            s2_func_ff;
   logic [asd_pkg::SQ_BITS-1:0]           s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic [asd_pkg::DIFF_BITS-1:0]         s2_abs_ff;

   logic signed [2*asd_pkg::DIFF_BITS-1:0] prod_x, prod_y, prod_z;
   logic [asd_pkg::DIFF_BITS-1:0]         abs_x, abs_y, abs_z;
   logic [asd_pkg::DIFF_BITS-1:0]         abs_in;
   logic [asd_pkg::RAD_BITS-1:0]          ext_x, ext_y, ext_z;
   asd_pkg::cell_type                     cell_in;
   asd_pkg::cell_type                     cell_ff;

   // Stage 1 takes the signed differences.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_func_ff <= in_req.func;
      s1_dx_ff   <= {in_req.a_x[C-1], in_req.a_x} - {in_req.b_x[C-1], in_req.b_x};
      s1_dy_ff   <= {in_req.a_y[C-1], in_req.a_y} - {in_req.b_y[C-1], in_req.b_y};
      s1_dz_ff   <= {in_req.a_z[C-1], in_req.a_z} - {in_req.b_z[C-1], in_req.b_z};
   end

   // The square of a signed difference equals that of its magnitude.
   assign prod_x = s1_dx_ff * s1_dx_ff;
   assign prod_y = s1_dy_ff * s1_dy_ff;
   assign prod_z = s1_dz_ff * s1_dz_ff;

   assign abs_x = s1_dx_ff[asd_pkg::DIFF_BITS-1] ? -s1_dx_ff : s1_dx_ff;
   assign abs_y = s1_dy_ff[asd_pkg::DIFF_BITS-1] ? -s1_dy_ff : s1_dy_ff;
   assign abs_z = s1_dz_ff[asd_pkg::DIFF_BITS-1] ? -s1_dz_ff : s1_dz_ff;

   // Single-axis modes pass the magnitude of their axis.
   always_comb begin
      case (s1_func_ff)
         asd_pkg::FUNC_X: abs_in = abs_x;
         asd_pkg::FUNC_Y: abs_in = abs_y;
         asd_pkg::FUNC_Z: abs_in = abs_z;
         default:         abs_in = '0;
      endcase
   end

   // Stage 2 holds the squares and the selected magnitude.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_func_ff <= s1_func_ff;
      s2_sqx_ff  <= prod_x[asd_pkg::SQ_BITS-1:0];
      s2_sqy_ff  <= prod_y[asd_pkg::SQ_BITS-1:0];
      s2_sqz_ff  <= prod_z[asd_pkg::SQ_BITS-1:0];
      s2_abs_ff  <= abs_in;
   end

   // Each axis joins the sum only when the mode includes it.
   always_comb begin
      ext_x = '0;
      ext_y = '0;
      ext_z = '0;
      if (s2_func_ff inside {asd_pkg::FUNC_ALL, asd_pkg::FUNC_XY, asd_pkg::FUNC_XZ}) begin
         ext_x = asd_pkg::RAD_BITS'(s2_sqx_ff);
      end
      if (s2_func_ff inside {asd_pkg::FUNC_ALL, asd_pkg::FUNC_XY, asd_pkg::FUNC_YZ}) begin
         ext_y = asd_pkg::RAD_BITS'(s2_sqy_ff);
      end
      if (s2_func_ff inside {asd_pkg::FUNC_ALL, asd_pkg::FUNC_XZ, asd_pkg::FUNC_YZ}) begin
         ext_z = asd_pkg::RAD_BITS'(s2_sqz_ff);
      end
   end

   // Build the record that enters the first square root cell.
   always_comb begin
      cell_in.valid   = s2_valid_ff;
      cell_in.sqrt_en = s2_func_ff inside {asd_pkg::FUNC_ALL, asd_pkg::FUNC_XY,
                                           asd_pkg::FUNC_XZ, asd_pkg::FUNC_YZ};
      cell_in.err     = (s2_func_ff == asd_pkg::FUNC_BAD);
      cell_in.direct  = s2_abs_ff;
      cell_in.rad     = ext_x + ext_y + ext_z;
      cell_in.rem     = '0;
      cell_in.root    = '0;
   end

   // Stage 3 holds the radicand.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
      cell_ff.sqrt_en <= cell_in.sqrt_en;
      cell_ff.err     <= cell_in.err;
      cell_ff.direct  <= cell_in.direct;
      cell_ff.rad     <= cell_in.rad;
      cell_ff.rem     <= cell_in.rem;
      cell_ff.root    <= cell_in.root;
   end

   assign out_cell = cell_ff;

endmodule

>>> rtl/core/asd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// asd_sqrt_cell: one bit of the digit-by-digit square root
// Shifts the next two radicand bits into the partial remainder, tries the
// next root bit and passes the updated record to the following cell.
// ----------------------------------------------------------------------------
module asd_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  asd_pkg::cell_type cell_in,
   output asd_pkg::cell_type cell_out
);

   logic [asd_pkg::REM_BITS-1:0] rem_sh;
   logic [asd_pkg::REM_BITS-1:0] trial;
   logic                         fits;
   asd_pkg::cell_type            next_in;
   asd_pkg::cell_type            next_ff;

   // The partial remainder never uses its top two bits before the shift.
   assign rem_sh = {cell_in.rem[asd_pkg::REM_BITS-3:0],
                    cell_in.rad[asd_pkg::RAD_BITS-1 -: 2]};
   assign trial  = {cell_in.root, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      next_in      = cell_in;
      next_in.rad  = {cell_in.rad[asd_pkg::RAD_BITS-3:0], 2'b00};
      next_in.rem  = fits ? (rem_sh - trial) : rem_sh;
      next_in.root = {cell_in.root[asd_pkg::ROOT_BITS-2:0], fits};
   end

   // Only the valid flag is control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else begin
         next_ff.valid <= next_in.valid;
      end
      next_ff.sqrt_en <= next_in.sqrt_en;
      next_ff.err     <= next_in.err;
      next_ff.direct  <= next_in.direct;
      next_ff.rad     <= next_in.rad;
      next_ff.rem     <= next_in.rem;
      next_ff.root    <= next_in.root;
   end

   assign cell_out = next_ff;

endmodule

>>> rtl/core/axis_selectable_distance.sv
// ----------------------------------------------------------------------------
// axis_selectable_distance: distance between two 3D points by axis mode
// An accepted request passes three front stages, the square root chain of
// one cell per root bit (33) and the result register to its result strobe.
// Throughput: one request per cycle; busy is low whenever reset is low.
// Reset (synchronous) clears every valid flag; the datapath is not reset.
// ----------------------------------------------------------------------------
module axis_selectable_distance (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  asd_pkg::req_type req_data,
   output logic             rsp_valid,
   output asd_pkg::rsp_type rsp_data
);

   asd_pkg::cell_type chain [0:asd_pkg::ROOT_BITS];
   logic              accept;
   logic              rsp_valid_ff;
   asd_pkg::rsp_type  rsp_data_ff;
   asd_pkg::rsp_type  rsp_data_in;
   asd_pkg::cell_type last;

   // No request is taken during reset.
   assign busy   = reset;
   assign accept = start && !busy;

   asd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_req   (req_data),
      .out_cell (chain[0])
   );

   // One cell per root bit.
   for (genvar i = 0; i < asd_pkg::ROOT_BITS; i++) begin : g_cell
      asd_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign last = chain[asd_pkg::ROOT_BITS];

   // Pick the root, the single-axis magnitude or zero for an undefined mode.
   always_comb begin
      rsp_data_in.mode_error = last.err;
      if (last.err) begin
         rsp_data_in.dist_res = '0;
      end else if (last.sqrt_en) begin
         rsp_data_in.dist_res = asd_pkg::DIST_BITS'(last.root);
      end else begin
         rsp_data_in.dist_res = asd_pkg::DIST_BITS'(last.direct);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/asd_checker.sv
// ----------------------------------------------------------------------------
// asd_checker: port-level checks of the axis selectable distance block
// Relates each result strobe to the request taken a fixed latency earlier.
// ----------------------------------------------------------------------------
module asd_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input asd_pkg::req_type req_data,
   input logic             rsp_valid,
   input asd_pkg::rsp_type rsp_data
);

   localparam int LAT = asd_pkg::LATENCY;
   localparam int C   = asd_pkg::COORD_BITS;

   logic                                 accept;
   logic signed [asd_pkg::DIFF_BITS-1:0] dx;
   logic [asd_pkg::DIFF_BITS-1:0]        abs_x;

   assign accept = start && !busy;
   assign dx     = {req_data.a_x[C-1], req_data.a_x} - {req_data.b_x[C-1], req_data.b_x};
   assign abs_x  = dx[asd_pkg::DIFF_BITS-1] ? -dx : dx;

   // Every accepted request gives a result after the fixed latency.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("accepted request gave no result");

   // No result appears without a request taken at the matching time.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without a matching request");

   // The error flag tracks the undefined mode and forces a zero distance.
   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode_error == ($past(req_data.func, LAT) == asd_pkg::FUNC_BAD))
                    && (!rsp_data.mode_error || rsp_data.dist_res == '0))
      else $error("mode error flag or its zero distance is wrong");

   // X-only mode returns the exact magnitude of the X difference.
   a_x_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.func, LAT) == asd_pkg::FUNC_X)
         |-> rsp_data.dist_res == asd_pkg::DIST_BITS'($past(abs_x, LAT)))
      else $error("X distance differs from the coordinate difference");

endmodule

bind axis_selectable_distance asd_checker u_asd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

>>> test/axis_selectable_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_selectable_distance_tb: self-checking bench for the distance block
// Streams point pairs in every axis mode and predicts each distance in fixed
// point: absolute differences, wide sums of squares and a bitwise floor root.
// Each result strobe is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module axis_selectable_distance_tb;

   localparam int RANDOM_REQUESTS = 700;
   localparam int PHASE_COUNT     = 4;
   localparam int STALL_LIMIT     = 2000;
   localparam logic signed [asd_pkg::COORD_BITS-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [asd_pkg::COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [asd_pkg::COORD_BITS-1:0] COORD_ONE = 32'sh0001_0000;

   // Keeps the predicted distances in request order and checks each result.
   class distance_scoreboard;
      asd_pkg::rsp_type pending_q[$];
      int               mismatches;
      int               checked;

      function new();
         mismatches = 0;
         checked    = 0;
      endfunction

      // Absolute difference of two signed coordinates, one bit wider.
      function logic [asd_pkg::DIFF_BITS-1:0] axis_gap(
         logic signed [asd_pkg::COORD_BITS-1:0] p,
         logic signed [asd_pkg::COORD_BITS-1:0] q);
         logic signed [asd_pkg::DIFF_BITS-1:0] d;
         d = {p[asd_pkg::COORD_BITS-1], p} - {q[asd_pkg::COORD_BITS-1], q};
         return d < 0 ? -d : d;
      endfunction

      // Exact square of a difference at the width of the root search.
      function logic [67:0] gap_square(logic [asd_pkg::DIFF_BITS-1:0] g);
         logic [67:0] w;
         w = 68'(g);
         return w * w;
      endfunction

      // Distance and error flag for one pair of points.
      function asd_pkg::rsp_type predict_distance(asd_pkg::req_type r);
         logic [asd_pkg::DIFF_BITS-1:0] dx, dy, dz;
         logic [67:0]                   radicand;
         logic [67:0]                   trial_sq;
         logic [asd_pkg::DIST_BITS-1:0] root, trial;
         logic                          use_root;
         asd_pkg::rsp_type              p;
         dx       = axis_gap(r.a_x, r.b_x);
         dy       = axis_gap(r.a_y, r.b_y);
         dz       = axis_gap(r.a_z, r.b_z);
         radicand = '0;
         use_root = 1'b1;
         p        = '0;
         case (r.func)
            asd_pkg::FUNC_ALL:
               radicand = gap_square(dx) + gap_square(dy) + gap_square(dz);
            asd_pkg::FUNC_XY:  radicand = gap_square(dx) + gap_square(dy);
            asd_pkg::FUNC_XZ:  radicand = gap_square(dx) + gap_square(dz);
            asd_pkg::FUNC_YZ:  radicand = gap_square(dy) + gap_square(dz);
            asd_pkg::FUNC_X: begin
               use_root   = 1'b0;
               p.dist_res = asd_pkg::DIST_BITS'(dx);
            end
            asd_pkg::FUNC_Y: begin
               use_root   = 1'b0;
               p.dist_res = asd_pkg::DIST_BITS'(dy);
            end
            asd_pkg::FUNC_Z: begin
               use_root   = 1'b0;
               p.dist_res = asd_pkg::DIST_BITS'(dz);
            end
            default: begin
               use_root     = 1'b0;
               p.mode_error = 1'b1;
            end
         endcase
         // Floor square root, one bit at a time from the top.
         if (use_root) begin
            root = '0;
            for (int b = asd_pkg::DIST_BITS - 1; b >= 0; b--) begin
               trial    = root | (asd_pkg::DIST_BITS'(1) << b);
               trial_sq = 68'(trial) * 68'(trial);
               if (trial_sq <= radicand)
                  root = trial;
            end
            p.dist_res = root;
         end
         return p;
      endfunction

      function void note_request(asd_pkg::req_type r);
         pending_q.push_back(predict_distance(r));
      endfunction

      function void check_result(asd_pkg::rsp_type got);
         asd_pkg::rsp_type want;
         if (pending_q.size() == 0) begin
            $error("result with no request outstanding: dist_res=%0h mode_error=%0b",
                   got.dist_res, got.mode_error);
            mismatches++;
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (got.dist_res !== want.dist_res) begin
            $error("dist_res: expected %0h, actual %0h", want.dist_res, got.dist_res);
            mismatches++;
         end
         if (got.mode_error !== want.mode_error) begin
            $error("mode_error: expected %0b, actual %0b", want.mode_error,
                   got.mode_error);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   asd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   asd_pkg::rsp_type rsp_data;

   distance_scoreboard distance_sb = new();
   int stall_cycles = 0;
   int mode_count[8];

   axis_selectable_distance DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: record accepted requests, check results and watch for a hang.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         distance_sb.note_request(req_data);
         mode_count[req_data.func]++;
      end
      if (!reset && rsp_valid)
         distance_sb.check_result(rsp_data);
      if ((!reset && start && !busy) || (!reset && rsp_valid))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic asd_pkg::req_type make_request(
      logic [2:0] f,
      logic signed [asd_pkg::COORD_BITS-1:0] ax,
      logic signed [asd_pkg::COORD_BITS-1:0] ay,
      logic signed [asd_pkg::COORD_BITS-1:0] az,
      logic signed [asd_pkg::COORD_BITS-1:0] bx,
      logic signed [asd_pkg::COORD_BITS-1:0] by,
      logic signed [asd_pkg::COORD_BITS-1:0] bz);
      asd_pkg::req_type r;
      r.func = f;
      r.a_x  = ax;
      r.a_y  = ay;
      r.a_z  = az;
      r.b_x  = bx;
      r.b_y  = by;
      r.b_z  = bz;
      return r;
   endfunction

   // Coordinates mix full-range values, extremes and small distances.
   function automatic logic signed [asd_pkg::COORD_BITS-1:0] random_coord();
      logic signed [asd_pkg::COORD_BITS-1:0] c;
      case ($urandom_range(0, 5))
         0:       c = COORD_MAX;
         1:       c = COORD_MIN;
         2:       c = $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
         3:       c = '0;
         default: c = $urandom;
      endcase
      return c;
   endfunction

   function automatic asd_pkg::req_type random_request();
      asd_pkg::req_type r;
      r = make_request(3'($urandom_range(asd_pkg::FUNC_ALL, asd_pkg::FUNC_BAD)),
                       random_coord(), random_coord(), random_coord(),
                       random_coord(), random_coord(), random_coord());
      // Now and then the points coincide on some or all axes.
      if ($urandom_range(0, 9) == 0) begin
         r.b_x = r.a_x;
         r.b_y = r.a_y;
         r.b_z = r.a_z;
      end else if ($urandom_range(0, 7) == 0) begin
         r.b_y = r.a_y;
      end
      return r;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic push_request(asd_pkg::req_type item);
      bit taken;
      req_data <= item;
      start    <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic idle_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      asd_pkg::req_type directed_q[$];
      int               idle_pct[PHASE_COUNT];
      int               wait_cycles;

      idle_pct = '{0, 52, 14, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: extremes, coincident points and exact roots.
      for (int f = asd_pkg::FUNC_ALL; f <= asd_pkg::FUNC_BAD; f++) begin
         directed_q.push_back(make_request(3'(f), COORD_MAX, COORD_MAX, COORD_MAX,
                                           COORD_MIN, COORD_MIN, COORD_MIN));
         directed_q.push_back(make_request(3'(f), 32'sh1234_5678, COORD_MIN, -7,
                                           32'sh1234_5678, COORD_MIN, -7));
      end
      directed_q.push_back(make_request(asd_pkg::FUNC_ALL, COORD_MIN, COORD_MIN,
                                        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      directed_q.push_back(make_request(asd_pkg::FUNC_XY, 3 * COORD_ONE,
                                        4 * COORD_ONE, 0, 0, 0, 0));
      directed_q.push_back(make_request(asd_pkg::FUNC_ALL, 2 * COORD_ONE,
                                        -3 * COORD_ONE, 6 * COORD_ONE, 0, 0, 0));
      directed_q.push_back(make_request(asd_pkg::FUNC_YZ, 0, 1, 1, 0, 0, 0));
      directed_q.push_back(make_request(asd_pkg::FUNC_BAD, 0, 0, 0, 0, 0, 0));
      foreach (directed_q[i])
         push_request(directed_q[i]);

      // Random requests in phases of different sender idling.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         for (int n = 0; n < RANDOM_REQUESTS / PHASE_COUNT; n++) begin
            if ($urandom_range(1, 100) <= idle_pct[ph])
               idle_sender($urandom_range(1, 4));
            push_request(random_request());
         end
      end
      idle_sender(0);

      // Drain: the monitor's stall limit ends a hung run.
      while (distance_sb.pending_q.size() != 0)
         @(posedge clock);
      wait_cycles = asd_pkg::LATENCY + 8;
      repeat (wait_cycles) @(posedge clock);

      $display("Checked %0d results over all eight axis modes, %0d mismatches.",
               distance_sb.checked, distance_sb.mismatches);
      $display("Requests per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               mode_count[0], mode_count[1], mode_count[2], mode_count[3],
               mode_count[4], mode_count[5], mode_count[6], mode_count[7]);
      if (distance_sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
